// File: rtl/core/bins_pkg.sv
// Shared constants, types and window rule function for the notch smoothing block.
`default_nettype none
package bins_pkg;

	localparam int SIDE_DEF = 64;
	localparam int ROW_W    = 64;
	localparam int NUM_W    = 6;

	localparam logic [1:0] CELL_CLR  = 2'd0;
	localparam logic [1:0] CELL_SET  = 2'd1;
	localparam logic [1:0] CELL_MARK = 2'd2;

	typedef logic [8:0][1:0] win_t;

	typedef struct packed {
		logic             load_wr;
		logic             top_wr;
		logic             rd_en;
		logic             shift;
		logic             rotate;
		logic             apply;
		logic             out_load;
		logic             out_last;
		logic [NUM_W-1:0] addr_rd;
		logic [NUM_W-1:0] addr_wr;
		logic [NUM_W-1:0] out_num;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

	localparam logic [8:0] RULE_ZERO [8] = '{
		9'h002, 9'h005, 9'h020, 9'h104, 9'h080, 9'h140, 9'h008, 9'h041
	};
	localparam logic [3:0] RULE_POS [8] = '{
		4'd1, 4'd1, 4'd5, 4'd5, 4'd7, 4'd7, 4'd3, 4'd3
	};
	localparam logic [1:0] RULE_VAL [8] = '{
		CELL_SET, CELL_MARK, CELL_SET, CELL_MARK,
		CELL_SET, CELL_MARK, CELL_SET, CELL_MARK
	};

	function automatic win_t smooth_window(win_t w_in);
		win_t w;
		logic hit;
		w = w_in;
		for (int r = 0; r < 8; r++) begin
			hit = 1'b1;
			for (int k = 0; k < 9; k++) begin
				if ((w[k] != CELL_CLR) == RULE_ZERO[r][k]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				w[RULE_POS[r]] = RULE_VAL[r];
			end
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/bins_dpath.sv
// Datapath: frame memory, three row registers with window update, and result register.
`default_nettype none
module bins_dpath #(
	parameter int SIDE = bins_pkg::SIDE_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bins_pkg::cmd_t             cmd,
	output bins_pkg::sts_t                  sts,
	input  wire logic [bins_pkg::ROW_W-1:0] row_bits,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output logic [bins_pkg::ROW_W-1:0]      out_row_bits,
	output logic [bins_pkg::NUM_W-1:0]      out_row_number,
	output logic                            last_row
);
	localparam int AW = $clog2(SIDE);

	typedef logic [SIDE-1:0][1:0] row_t;

	row_t mem [SIDE];
	row_t rdata_q, top_q, mid_q, bot_q;
	row_t load_row, top_n, mid_n, bot_n;
	logic [bins_pkg::ROW_W-1:0] bits_n;
	bins_pkg::win_t win, win_n;
	logic valid_q;

	always_comb begin
		for (int c = 0; c < SIDE; c++) begin
			load_row[c] = {1'b0, row_bits[bins_pkg::ROW_W-1-c]};
		end
		bits_n = '0;
		for (int c = 0; c < SIDE; c++) begin
			bits_n[bins_pkg::ROW_W-1-c] = (rdata_q[c] == bins_pkg::CELL_SET);
		end
		for (int k = 0; k < 3; k++) begin
			win[k]     = top_q[k];
			win[3 + k] = mid_q[k];
			win[6 + k] = bot_q[k];
		end
		win_n = bins_pkg::smooth_window(win);
		top_n = top_q;
		mid_n = mid_q;
		bot_n = bot_q;
		if (cmd.apply) begin
			for (int k = 0; k < 3; k++) begin
				top_n[k] = win_n[k];
				mid_n[k] = win_n[3 + k];
				bot_n[k] = win_n[6 + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			mem[cmd.addr_wr[AW-1:0]] <= load_row;
		end else if (cmd.top_wr) begin
			mem[cmd.addr_wr[AW-1:0]] <= top_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[cmd.addr_rd[AW-1:0]];
		end
		if (cmd.shift) begin
			top_q <= mid_q;
			mid_q <= bot_q;
			bot_q <= rdata_q;
		end else if (cmd.rotate) begin
			top_q <= {top_n[0], top_n[SIDE-1:1]};
			mid_q <= {mid_n[0], mid_n[SIDE-1:1]};
			bot_q <= {bot_n[0], bot_n[SIDE-1:1]};
		end
		if (cmd.out_load) begin
			out_row_bits   <= bits_n;
			out_row_number <= cmd.out_num;
			last_row       <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign res_valid    = valid_q;
	assign sts.out_busy = valid_q;

endmodule
`default_nettype wire

// File: rtl/core/bins_ctrl.sv
// Controller: sequences row loading, the window pass, write-back and row emission.
`default_nettype none
module bins_ctrl #(
	parameter int SIDE = bins_pkg::SIDE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           row_valid,
	output logic                row_stall,
	input  wire bins_pkg::sts_t sts,
	output bins_pkg::cmd_t      cmd
);
	localparam int AW = $clog2(SIDE);
	localparam int NW = bins_pkg::NUM_W;

	typedef enum logic [2:0] {
		S_LOAD, S_PRIME, S_SCAN, S_ADV, S_FLUSH, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
	} state_t;

	state_t state_q;
	logic [AW-1:0] rows_q, row_q, col_q;
	logic [1:0] cnt_q;
	logic accept;

	assign row_stall = (state_q != S_LOAD);
	assign accept    = row_valid && !row_stall;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_LOAD: begin
				cmd.load_wr = accept;
				cmd.addr_wr = NW'(rows_q);
			end
			S_PRIME: begin
				cmd.rd_en   = (cnt_q != 2'd3);
				cmd.addr_rd = NW'(cnt_q);
				cmd.shift   = (cnt_q != 2'd0);
			end
			S_SCAN: begin
				cmd.rotate  = 1'b1;
				cmd.apply   = (col_q < AW'(SIDE - 2));
				cmd.rd_en   = (col_q == AW'(SIDE - 1)) && (row_q != AW'(SIDE - 2));
				cmd.addr_rd = NW'(row_q + AW'(2));
			end
			S_ADV: begin
				cmd.top_wr  = 1'b1;
				cmd.shift   = 1'b1;
				cmd.addr_wr = NW'(row_q - AW'(1));
			end
			S_FLUSH: begin
				cmd.top_wr  = 1'b1;
				cmd.shift   = 1'b1;
				cmd.addr_wr = NW'(row_q + AW'(cnt_q));
			end
			S_EMIT_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.addr_rd = NW'(rows_q);
			end
			S_EMIT_LD: begin
				cmd.out_load = 1'b1;
				cmd.out_num  = NW'(rows_q);
				cmd.out_last = (rows_q == AW'(SIDE - 1));
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			rows_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (rows_q == AW'(SIDE - 1)) begin
							rows_q  <= '0;
							cnt_q   <= '0;
							state_q <= S_PRIME;
						end else begin
							rows_q <= rows_q + AW'(1);
						end
					end
				end
				S_PRIME: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						row_q   <= AW'(1);
						col_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (col_q == AW'(SIDE - 1)) begin
						col_q   <= '0;
						state_q <= S_ADV;
					end else begin
						col_q <= col_q + AW'(1);
					end
				end
				S_ADV: begin
					if (row_q == AW'(SIDE - 2)) begin
						cnt_q   <= '0;
						state_q <= S_FLUSH;
					end else begin
						row_q   <= row_q + AW'(1);
						state_q <= S_SCAN;
					end
				end
				S_FLUSH: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd1) begin
						rows_q  <= '0;
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					state_q <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (!sts.out_busy) begin
						if (rows_q == AW'(SIDE - 1)) begin
							rows_q  <= '0;
							state_q <= S_LOAD;
						end else begin
							rows_q  <= rows_q + AW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/binary_image_notch_smoothing.sv
// Top level of the binary image notch smoothing block.
// Rows are taken one per cycle while the block is loading, SIDE rows per image. After
// the last row the block runs one window step per cycle on three row registers that
// rotate under a fixed 3x3 window: it primes the registers, scans each interior row
// and writes rows back, then writes back the tail. Rows then go out one at a time
// through the single frame memory read port, each once the one before it is taken;
// marked pixels read as clear. No new row is taken until the last result is taken.
`default_nettype none
module binary_image_notch_smoothing #(
	parameter int SIDE = bins_pkg::SIDE_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       row_valid,
	output logic                            row_stall,
	input  wire logic [bins_pkg::ROW_W-1:0] row_bits,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output logic [bins_pkg::ROW_W-1:0]      out_row_bits,
	output logic [bins_pkg::NUM_W-1:0]      out_row_number,
	output logic                            last_row
);
	bins_pkg::cmd_t cmd;
	bins_pkg::sts_t sts;

	bins_ctrl #(.SIDE(SIDE)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bins_dpath #(.SIDE(SIDE)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.row_bits       (row_bits),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.out_row_bits   (out_row_bits),
		.out_row_number (out_row_number),
		.last_row       (last_row)
	);

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Testbench for binary_image_notch_smoothing: row images in, smoothed rows checked against a predictor.
`timescale 1ns / 1ps
module tb_top;

	localparam int N = bins_pkg::SIDE_DEF;

	typedef struct {
		logic [bins_pkg::ROW_W-1:0] bits;
		int                         reps;
		bit                         chk;
		logic [bins_pkg::ROW_W-1:0] exp;
	} row_req_t;

	typedef struct {
		logic [bins_pkg::ROW_W-1:0] bits;
		logic [bins_pkg::NUM_W-1:0] num;
		logic                       last;
		bit                         chk;
		logic [bins_pkg::ROW_W-1:0] exp;
	} smooth_row_t;

	localparam logic [bins_pkg::ROW_W-1:0] ONES = '1;

	localparam int         DIR_DR [4]    = '{-1, 0, 1, 0};
	localparam int         DIR_DC [4]    = '{0, 1, 0, -1};
	localparam logic [8:0] NOTCH_MASK [4] = '{9'h002, 9'h020, 9'h080, 9'h008};
	localparam logic [8:0] SPUR_MASK [4]  = '{9'h005, 9'h104, 9'h140, 9'h041};

	logic                       clk;
	logic                       arst_n;
	logic                       row_valid;
	logic                       row_stall;
	logic [bins_pkg::ROW_W-1:0] row_bits;
	logic                       res_valid;
	logic                       res_stall;
	logic [bins_pkg::ROW_W-1:0] out_row_bits;
	logic [bins_pkg::NUM_W-1:0] out_row_number;
	logic                       last_row;

	bit                         row_chk;
	logic [bins_pkg::ROW_W-1:0] row_exp;

	logic [1:0]                 image [N][N];
	bit                         chk_tab [N];
	logic [bins_pkg::ROW_W-1:0] exp_tab [N];
	int                         rows_in;
	smooth_row_t                smooth_q [$];
	int                         mism;
	int                         res_seen;
	bit                         quiet;

	row_req_t dir_tab [] = '{
		'{64'h0, 64, 1'b1, 64'h0}, '{ONES, 64, 1'b1, ONES},
		'{ONES, 1, 1'b0, 64'h0}, '{ONES, 1, 1'b0, 64'h0},
		'{64'hFFFF_FFFF_FFEF_FFFF, 1, 1'b0, 64'h0},
		'{ONES, 1, 1'b0, 64'h0}, '{ONES, 1, 1'b0, 64'h0},
		'{64'h0000_0100_0000_0000, 1, 1'b0, 64'h0},
		'{ONES, 1, 1'b0, 64'h0}, '{ONES, 1, 1'b0, 64'h0}, '{64'h0, 1, 1'b0, 64'h0},
		'{64'h8000_0000_0000_0001, 1, 1'b0, 64'h0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 1, 1'b0, 64'h0},
		'{64'h5555_5555_5555_5555, 1, 1'b0, 64'h0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 1, 1'b0, 64'h0}, '{ONES, 1, 1'b0, 64'h0},
		'{64'h7FFF_FFFF_FFFF_FFFE, 1, 1'b0, 64'h0}, '{ONES, 1, 1'b0, 64'h0},
		'{64'hFFFF_0000_FFFF_0000, 1, 1'b0, 64'h0},
		'{ONES, 1, 1'b0, 64'h0}, '{64'h0123_4567_89AB_CDEF, 1, 1'b0, 64'h0},
		'{ONES, 1, 1'b0, 64'h0}, '{ONES, 44, 1'b0, 64'h0}
	};

	binary_image_notch_smoothing u_top (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_stall(row_stall), .row_bits(row_bits),
		.res_valid(res_valid), .res_stall(res_stall),
		.out_row_bits(out_row_bits), .out_row_number(out_row_number), .last_row(last_row)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit window_hit(int r, int c, logic [8:0] zeros);
		for (int k = 0; k < 9; k++) begin
			if ((image[r + k / 3 - 1][c + k % 3 - 1] != bins_pkg::CELL_CLR) == zeros[k]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic smooth_image();
		smooth_row_t e;
		for (int r = 1; r < N - 1; r++) begin
			for (int c = 1; c < N - 1; c++) begin
				for (int d = 0; d < 4; d++) begin
					if (window_hit(r, c, NOTCH_MASK[d])) begin
						image[r + DIR_DR[d]][c + DIR_DC[d]] = bins_pkg::CELL_SET;
					end
					if (window_hit(r, c, SPUR_MASK[d])) begin
						image[r + DIR_DR[d]][c + DIR_DC[d]] = bins_pkg::CELL_MARK;
					end
				end
			end
		end
		for (int r = 0; r < N; r++) begin
			e.bits = '0;
			for (int c = 0; c < N; c++) begin
				e.bits[bins_pkg::ROW_W - 1 - c] = (image[r][c] == bins_pkg::CELL_SET);
			end
			e.num  = bins_pkg::NUM_W'(r);
			e.last = (r == N - 1);
			e.chk  = chk_tab[r];
			e.exp  = exp_tab[r];
			smooth_q.push_back(e);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && row_valid && !row_stall) begin
			for (int c = 0; c < N; c++) begin
				image[rows_in][c] = {1'b0, row_bits[bins_pkg::ROW_W - 1 - c]};
			end
			chk_tab[rows_in] = row_chk;
			exp_tab[rows_in] = row_exp;
			rows_in = rows_in + 1;
			if (rows_in == N) begin
				rows_in = 0;
				smooth_image();
			end
		end
	end

	always @(posedge clk) begin
		smooth_row_t e;
		if (arst_n && res_valid && !res_stall) begin
			res_seen++;
			if (smooth_q.size() == 0) begin
				if (mism < 10) begin
					$display("unexpected row %0d bits %h", out_row_number, out_row_bits);
				end
				mism++;
			end else begin
				e = smooth_q.pop_front();
				if (e.bits !== out_row_bits || e.num !== out_row_number || e.last !== last_row
						|| (e.chk && e.exp !== out_row_bits)) begin
					if (mism < 10) begin
						$display("row mismatch: exp %0d %h %b got %0d %h %b",
							e.num, e.chk ? e.exp : e.bits, e.last,
							out_row_number, out_row_bits, last_row);
					end
					mism++;
				end
			end
		end
	end

	initial begin
		bit held;
		held = 1'b0;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && res_seen >= 80) begin
				held = 1'b1;
				res_stall <= 1'b1;
				repeat (600) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				res_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	function automatic logic [bins_pkg::ROW_W-1:0] pick_row();
		logic [bins_pkg::ROW_W-1:0] a, b, c;
		int mode;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		mode = $urandom_range(0, 9);
		if (mode < 6) return a | b | c;
		if (mode < 8) return a;
		if (mode == 8) return a & b;
		return ~(64'd1 << $urandom_range(0, 63));
	endfunction

	task automatic send_row(logic [bins_pkg::ROW_W-1:0] bits, bit chk,
			logic [bins_pkg::ROW_W-1:0] exp);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			row_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		row_valid <= 1'b1;
		row_bits  <= bits;
		row_chk   <= chk;
		row_exp   <= exp;
		do @(posedge clk); while (row_stall);
	endtask

	task automatic drain_results();
		row_valid <= 1'b0;
		@(posedge clk);
		while (smooth_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		row_valid = 1'b0;
		row_bits  = '0;
		row_chk   = 1'b0;
		row_exp   = '0;
		rows_in   = 0;
		mism      = 0;
		res_seen  = 0;
		quiet     = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < dir_tab.size(); i++) begin
			for (int j = 0; j < dir_tab[i].reps; j++) begin
				send_row(dir_tab[i].bits, dir_tab[i].chk, dir_tab[i].exp);
			end
			// hold the sender until the blank image has fully come back
			if (i == 0) drain_results();
		end
		for (int i = 0; i < 3 * N; i++) begin
			quiet = (i >= 2 * N);
			send_row(pick_row(), 1'b0, '0);
		end
		drain_results();
		repeat (20) @(posedge clk);
		if (mism == 0 && smooth_q.size() == 0) begin
			$display("binary_image_notch_smoothing regression: pass");
		end else begin
			$display("binary_image_notch_smoothing regression: fail");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("binary_image_notch_smoothing regression: fail");
		$finish;
	end

endmodule
